FILE: rtl/core/cftlp_pkg.sv
// shared types and constants for the can frame text line parser
package cftlp_pkg;

  localparam int MaxBytes = 8;
  localparam int HexCntW  = $clog2(2 * MaxBytes + 1);
  localparam int NibW     = $clog2(2 * MaxBytes);

  localparam logic [31:0] BlockedIdReset = 32'h0000_0229;
  localparam logic [7:0]  NameLimitReset = 8'd32;
  localparam logic [15:0] RepeatDefault  = 16'd1;
  localparam logic [15:0] DelayDefault   = 16'd50;
  localparam logic [15:0] NumMax         = 16'hFFFF;

  // register indexes on the write port
  localparam logic [1:0] RegBlockedId = 2'd0;
  localparam logic [1:0] RegNameLimit = 2'd1;

  typedef enum logic [2:0] {
    PH_START,
    PH_COMMENT,
    PH_NAME,
    PH_ID,
    PH_DATA,
    PH_REST,
    PH_EMPTY,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    KIND_EMPTY     = 3'd0,
    KIND_NAME      = 3'd1,
    KIND_STEP      = 3'd2,
    KIND_BLOCKED   = 3'd3,
    KIND_ERROR     = 3'd4,
    KIND_NAME_CHAR = 3'd5
  } kind_t;

  typedef struct packed {
    phase_t             phase;
    logic [31:0]        id_value;
    logic [3:0]         id_digit_count;
    logic [63:0]        data_bytes;
    logic [HexCntW-1:0] hex_digit_count;
    logic [3:0]         keyword_position;
    logic [15:0]        number_value;
    logic [15:0]        repeat_value;
    logic [15:0]        delay_value;
    logic [7:0]         name_emitted;
  } line_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_char;
    logic [31:0] can_id;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic [15:0] repeat_count;
    logic [15:0] frame_delay;
  } result_t;

  localparam line_state_t LineInit = '{
    phase:            PH_START,
    id_value:         32'd0,
    id_digit_count:   4'd0,
    data_bytes:       64'd0,
    hex_digit_count:  '0,
    keyword_position: 4'd0,
    number_value:     16'd0,
    repeat_value:     RepeatDefault,
    delay_value:      DelayDefault,
    name_emitted:     8'd0
  };

endpackage

FILE: rtl/core/cftlp_if.sv
// valid/ready channel interfaces for characters in and results out
interface cftlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source(output valid, ch, line_end, input ready);
  modport sink(input valid, ch, line_end, output ready);
endinterface

interface cftlp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  name_char;
  logic [31:0] can_id;
  logic [3:0]  byte_count;
  logic [63:0] payload;
  logic [15:0] repeat_count;
  logic [15:0] frame_delay;

  modport source(output valid, kind, name_char, can_id, byte_count, payload, repeat_count,
                 frame_delay, input ready);
  modport sink(input valid, kind, name_char, can_id, byte_count, payload, repeat_count,
               frame_delay, output ready);
endinterface

FILE: rtl/core/cftlp_step.sv
// next line state and result for one character or terminator beat
module cftlp_step import cftlp_pkg::*; (
  input  line_state_t st,
  input  logic [7:0]  ch,
  input  logic        line_end,
  input  logic [31:0] blocked_id,
  input  logic [7:0]  name_limit,
  output line_state_t st_next,
  output logic        res_valid,
  output result_t     res
);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;

  // keyword tracker positions in the rest of a frame line
  localparam logic [3:0] KpIdle     = 4'd0;
  localparam logic [3:0] KpRepFirst = 4'd1;
  localparam logic [3:0] KpRepLast  = 4'd6;
  localparam logic [3:0] KpDelFirst = 4'd7;
  localparam logic [3:0] KpDelLast  = 4'd11;
  localparam logic [3:0] KpRepNum   = 4'd12;
  localparam logic [3:0] KpDelNum   = 4'd13;
  localparam logic [3:0] KpDone     = 4'd15;

  // same field during a name comment
  localparam logic [3:0] NameLead = 4'd0;
  localparam logic [3:0] NameCopy = 4'd1;
  localparam logic [3:0] NameStop = 4'd2;
  localparam logic [3:0] NameKwLast = 4'd4;

  localparam logic [HexCntW-1:0] HexCntMax = HexCntW'(2 * MaxBytes);

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  function automatic logic is_stop(input logic [7:0] c);
    return c == ChNul || c == ChCr || c == ChLf;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] name_kw(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0:    r = 8'h6E; // n
      4'd1:    r = 8'h61; // a
      4'd2:    r = 8'h6D; // m
      4'd3:    r = 8'h65; // e
      4'd4:    r = 8'h3A; // :
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

  // expected char at each position of "repeat=" then "delay="
  function automatic logic [7:0] kw_char(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd1:    r = 8'h65; // e
      4'd2:    r = 8'h70; // p
      4'd3:    r = 8'h65; // e
      4'd4:    r = 8'h61; // a
      4'd5:    r = 8'h74; // t
      4'd6:    r = 8'h3D; // =
      4'd7:    r = 8'h65; // e
      4'd8:    r = 8'h6C; // l
      4'd9:    r = 8'h61; // a
      4'd10:   r = 8'h79; // y
      4'd11:   r = 8'h3D; // =
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_restart(input logic [7:0] lc);
    return (lc == 8'h72) ? KpRepFirst : ((lc == 8'h64) ? KpDelFirst : KpIdle);
  endfunction

  function automatic line_state_t commit_num(input line_state_t s);
    line_state_t r;
    r = s;
    if (s.keyword_position == KpRepNum) begin
      r.repeat_value = (s.number_value == 16'd0) ? RepeatDefault : s.number_value;
    end else if (s.keyword_position == KpDelNum) begin
      r.delay_value = s.number_value;
    end
    return r;
  endfunction

  function automatic line_state_t rest_char(input line_state_t s, input logic [7:0] c);
    line_state_t r;
    logic [7:0]  lc;
    logic [19:0] acc;
    logic [3:0]  kp;
    logic        in_num;
    r      = s;
    lc     = to_lower(c);
    acc    = 20'(s.number_value) * 20'd10 + 20'(c - ChZero);
    kp     = s.keyword_position;
    in_num = (kp == KpRepNum) || (kp == KpDelNum);
    if (kp != KpDone) begin
      if (c == ChNul) begin
        r = commit_num(s);
        r.keyword_position = KpDone;
      end else if (in_num && is_digit(c)) begin
        r.number_value = (acc > 20'(NumMax)) ? NumMax : acc[15:0];
      end else begin
        if (in_num) begin
          r  = commit_num(s);
          kp = KpIdle;
        end
        if (kp >= KpRepFirst && kp <= KpDelLast && lc == kw_char(kp)) begin
          if (kp == KpRepLast) begin
            r.keyword_position = KpRepNum;
            r.number_value     = 16'd0;
          end else if (kp == KpDelLast) begin
            r.keyword_position = KpDelNum;
            r.number_value     = 16'd0;
          end else begin
            r.keyword_position = kp + 4'd1;
          end
        end else begin
          r.keyword_position = kw_restart(lc);
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [4:0]      hx;
    logic [7:0]      lc;
    logic [NibW-1:0] nib;
    logic            frame_ok;
    line_state_t     fin;
    line_state_t     tmp;

    st_next   = st;
    res_valid = 1'b0;
    res       = '0;
    hx        = hex_of(ch);
    lc        = to_lower(ch);
    nib       = NibW'({st.hex_digit_count[HexCntW-1:1], ~st.hex_digit_count[0]});
    fin       = commit_num(st);
    tmp       = st;
    frame_ok  = 1'b0;

    if (line_end) begin
      st_next   = LineInit;
      res_valid = 1'b1;
      res.kind  = KIND_ERROR;
      unique case (st.phase)
        PH_START, PH_COMMENT, PH_EMPTY: res.kind = KIND_EMPTY;
        PH_NAME:                        res.kind = KIND_NAME;
        PH_DATA:                        frame_ok = ~st.hex_digit_count[0];
        PH_REST:                        frame_ok = 1'b1;
        PH_ID, PH_ERROR:                res.kind = KIND_ERROR;
      endcase
      if (frame_ok) begin
        res.kind         = (fin.id_value == blocked_id) ? KIND_BLOCKED : KIND_STEP;
        res.can_id       = fin.id_value;
        res.byte_count   = 4'(st.hex_digit_count >> 1);
        res.payload      = fin.data_bytes;
        res.repeat_count = fin.repeat_value;
        res.frame_delay  = fin.delay_value;
      end
    end else begin
      unique case (st.phase)
        PH_START: begin
          if (is_blank(ch)) begin
            st_next.phase = PH_START;
          end else if (is_stop(ch)) begin
            st_next.phase = PH_EMPTY;
          end else if (ch == ChHash) begin
            st_next.phase            = PH_COMMENT;
            st_next.keyword_position = NameLead;
          end else begin
            st_next.phase = PH_ID;
            if (hx[4]) begin
              st_next.id_value       = 32'(hx[3:0]);
              st_next.id_digit_count = 4'd1;
            end
          end
        end
        PH_COMMENT: begin
          if (!(st.keyword_position == NameLead && is_blank(ch))) begin
            if (st.keyword_position <= NameKwLast && lc == name_kw(st.keyword_position)) begin
              if (st.keyword_position == NameKwLast) begin
                st_next.phase            = PH_NAME;
                st_next.keyword_position = NameLead;
              end else begin
                st_next.keyword_position = st.keyword_position + 4'd1;
              end
            end else begin
              st_next.phase = PH_EMPTY;
            end
          end
        end
        PH_NAME: begin
          if (st.keyword_position < NameStop) begin
            if (is_stop(ch)) begin
              st_next.keyword_position = NameStop;
            end else if (!(st.keyword_position == NameLead && is_blank(ch))) begin
              st_next.keyword_position = NameCopy;
              // keep room for the terminating nul of the name buffer
              if (name_limit != 8'd0 &&
                  ({1'b0, st.name_emitted} + 9'd1) < {1'b0, name_limit}) begin
                st_next.name_emitted = st.name_emitted + 8'd1;
                res_valid            = 1'b1;
                res.kind             = KIND_NAME_CHAR;
                res.name_char        = ch;
              end
            end
          end
        end
        PH_ID: begin
          if (ch == ChHash) begin
            if (st.id_digit_count == 4'd0 || st.id_digit_count > 4'd8) begin
              st_next.phase = PH_ERROR;
            end else begin
              st_next.phase           = PH_DATA;
              st_next.hex_digit_count = '0;
              st_next.data_bytes      = 64'd0;
            end
          end else if (ch == ChNul) begin
            st_next.phase = PH_ERROR;
          end else if (hx[4]) begin
            st_next.id_value = {st.id_value[27:0], hx[3:0]};
            if (st.id_digit_count < 4'd9) begin
              st_next.id_digit_count = st.id_digit_count + 4'd1;
            end
          end else begin
            // a non-hex char restarts the id run
            st_next.id_value       = 32'd0;
            st_next.id_digit_count = 4'd0;
          end
        end
        PH_DATA: begin
          if (hx[4]) begin
            if (st.hex_digit_count >= HexCntMax) begin
              st_next.phase = PH_ERROR;
            end else begin
              for (int k = 0; k < 2 * MaxBytes; k++) begin
                if (nib == NibW'(k)) begin
                  st_next.data_bytes[4*k +: 4] = st.data_bytes[4*k +: 4] | hx[3:0];
                end
              end
              st_next.hex_digit_count = st.hex_digit_count + HexCntW'(1);
            end
          end else if (st.hex_digit_count[0]) begin
            st_next.phase = PH_ERROR;
          end else begin
            tmp.phase            = PH_REST;
            tmp.keyword_position = KpIdle;
            st_next              = rest_char(tmp, ch);
          end
        end
        PH_REST: begin
          st_next = rest_char(st, ch);
        end
        PH_EMPTY, PH_ERROR: begin
          st_next = st;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/can_frame_text_line_parser_unit.sv
// can frame text line parser: one character beat in, at most one result beat out
//
//  channel     dir  handshake      payload
//  line_in     in   valid/ready    ch, line_end
//  result_out  out  valid/ready    kind, name_char, can_id, byte_count, payload,
//                                  repeat_count, frame_delay
//  wr_*        in   wr_en          wr_index, wr_data
//
// one beat per cycle unless stalled: the line state register updates in the cycle a
// beat is taken and its result lands in the output register on the same edge.
// the output register is the only stall point: line_in is ready whenever that register
// is empty or being drained in the same cycle.
// synchronous reset loads blocked_id 0x229, name_limit 32 and an empty line state.
module can_frame_text_line_parser_unit import cftlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  cftlp_char_if.sink            line_in,
  cftlp_result_if.source        result_out,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [31:0]           wr_data
);

  logic [31:0] blocked_id;
  logic [7:0]  name_limit;
  line_state_t st;
  line_state_t st_next;
  logic        step_valid;
  result_t     step_res;
  logic        res_valid;
  result_t     res;
  logic        accept;

  assign line_in.ready = ~res_valid | result_out.ready;
  assign accept        = line_in.valid & line_in.ready;

  cftlp_step u_step (
    .st         (st),
    .ch         (line_in.ch),
    .line_end   (line_in.line_end),
    .blocked_id (blocked_id),
    .name_limit (name_limit),
    .st_next    (st_next),
    .res_valid  (step_valid),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_id <= BlockedIdReset;
      name_limit <= NameLimitReset;
    end else if (wr_en) begin
      unique case (wr_index)
        RegBlockedId: blocked_id <= wr_data;
        RegNameLimit: name_limit <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LineInit;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && step_valid) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step_valid) begin
      res <= step_res;
    end
  end

  assign result_out.valid        = res_valid;
  assign result_out.kind         = res.kind;
  assign result_out.name_char    = res.name_char;
  assign result_out.can_id       = res.can_id;
  assign result_out.byte_count   = res.byte_count;
  assign result_out.payload      = res.payload;
  assign result_out.repeat_count = res.repeat_count;
  assign result_out.frame_delay  = res.frame_delay;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// testbench for the can frame text line parser: random text lines checked by a line predictor
module testbench;
  import cftlp_pkg::*;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;

  // keyword tracker positions in the tail of a frame line
  localparam logic [3:0] KwIdle     = 4'd0;
  localparam logic [3:0] KwRepFirst = 4'd1;
  localparam logic [3:0] KwRepLast  = 4'd6;
  localparam logic [3:0] KwDelFirst = 4'd7;
  localparam logic [3:0] KwDelLast  = 4'd11;
  localparam logic [3:0] KwRepNum   = 4'd12;
  localparam logic [3:0] KwDelNum   = 4'd13;
  localparam logic [3:0] KwDone     = 4'd15;
  localparam logic [3:0] KwNameLen  = 4'd5;

  // name copy positions
  localparam logic [3:0] NmSkip = 4'd0;
  localparam logic [3:0] NmCopy = 4'd1;
  localparam logic [3:0] NmStop = 4'd2;

  // indexes the block does not decode
  localparam logic [1:0] RegSpareA = 2'd2;
  localparam logic [1:0] RegSpareB = 2'd3;

  localparam int PhaseBeats = 190;

  class frame_line_checker;
    result_t     pending_results[$];
    int          errors = 0;
    logic [31:0] blocked_id = BlockedIdReset;
    logic [7:0]  name_limit = NameLimitReset;
    phase_t      cur_phase = PH_START;
    logic [31:0] frame_id = '0;
    int          id_digits = 0;
    logic [63:0] data_word = '0;
    int          nibbles = 0;
    logic [3:0]  kw_pos = KwIdle;
    int          dec_value = 0;
    logic [15:0] rep_setting = RepeatDefault;
    logic [15:0] delay_setting = DelayDefault;
    int          name_count = 0;
    string       name_word = "name:";
    string       rep_word = "repeat=";
    string       del_word = "delay=";

    function void clear_line();
      cur_phase = PH_START;
      frame_id = '0;
      id_digits = 0;
      data_word = '0;
      nibbles = 0;
      kw_pos = KwIdle;
      dec_value = 0;
      rep_setting = RepeatDefault;
      delay_setting = DelayDefault;
      name_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      if (idx == RegBlockedId) blocked_id = data;
      else if (idx == RegNameLimit) name_limit = data[7:0];
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == ChSpace || c == ChTab;
    endfunction

    function bit is_break(logic [7:0] c);
      return c == ChNul || c == ChCr || c == ChLf;
    endfunction

    function void commit_number();
      if (kw_pos == KwRepNum) rep_setting = (dec_value == 0) ? 16'd1 : 16'(dec_value);
      else if (kw_pos == KwDelNum) delay_setting = 16'(dec_value);
    endfunction

    function logic [3:0] kw_restart(logic [7:0] lc);
      return (lc == "r") ? KwRepFirst : ((lc == "d") ? KwDelFirst : KwIdle);
    endfunction

    // repeat= / delay= scan over the tail of a frame line
    function void tail_char(logic [7:0] c);
      logic [7:0] lc;
      int idx;
      if (kw_pos == KwDone) return;
      if (c == ChNul) begin
        commit_number();
        kw_pos = KwDone;
        return;
      end
      if (kw_pos == KwRepNum || kw_pos == KwDelNum) begin
        if (c >= "0" && c <= "9") begin
          dec_value = dec_value * 10 + (int'(c) - 48);
          if (dec_value > NumMax) dec_value = NumMax;
          return;
        end
        commit_number();
        kw_pos = KwIdle;
      end
      lc = to_lower(c);
      if (kw_pos >= KwRepFirst && kw_pos <= KwRepLast) begin
        if (lc == rep_word[kw_pos]) begin
          kw_pos++;
          if (kw_pos == KwDelFirst) begin
            kw_pos = KwRepNum;
            dec_value = 0;
          end
        end else begin
          kw_pos = kw_restart(lc);
        end
      end else if (kw_pos >= KwDelFirst && kw_pos <= KwDelLast) begin
        idx = kw_pos - KwRepLast;
        if (lc == del_word[idx]) begin
          idx++;
          if (idx == 6) begin
            kw_pos = KwDelNum;
            dec_value = 0;
          end else begin
            kw_pos = 4'(KwRepLast + idx);
          end
        end else begin
          kw_pos = kw_restart(lc);
        end
      end else begin
        kw_pos = kw_restart(lc);
      end
    endfunction

    // advance the line state by one accepted beat, queue what it should produce
    function void take_char(logic [7:0] c, logic line_end);
      result_t r;
      int h;
      int sh;
      r = '0;
      if (line_end) begin
        r.kind = KIND_ERROR;
        if (cur_phase == PH_START || cur_phase == PH_COMMENT || cur_phase == PH_EMPTY) begin
          r.kind = KIND_EMPTY;
        end else if (cur_phase == PH_NAME) begin
          r.kind = KIND_NAME;
        end else if ((cur_phase == PH_DATA && nibbles % 2 == 0) || cur_phase == PH_REST) begin
          commit_number();
          if (frame_id == blocked_id) r.kind = KIND_BLOCKED;
          else r.kind = KIND_STEP;
          r.can_id = frame_id;
          r.byte_count = 4'(nibbles / 2);
          r.payload = data_word;
          r.repeat_count = rep_setting;
          r.frame_delay = delay_setting;
        end
        pending_results.push_back(r);
        clear_line();
        return;
      end
      case (cur_phase)
        PH_START: begin
          if (is_blank(c)) begin
          end else if (is_break(c)) begin
            cur_phase = PH_EMPTY;
          end else if (c == ChHash) begin
            cur_phase = PH_COMMENT;
            kw_pos = KwIdle;
          end else begin
            cur_phase = PH_ID;
            h = hex_val(c);
            if (h >= 0) begin
              frame_id = 32'(h);
              id_digits = 1;
            end
          end
        end
        PH_COMMENT: begin
          if (kw_pos == KwIdle && is_blank(c)) begin
          end else if (kw_pos < KwNameLen && to_lower(c) == name_word[kw_pos]) begin
            kw_pos++;
            if (kw_pos == KwNameLen) begin
              cur_phase = PH_NAME;
              kw_pos = NmSkip;
            end
          end else begin
            cur_phase = PH_EMPTY;
          end
        end
        PH_NAME: begin
          if (kw_pos >= NmStop) begin
          end else if (is_break(c)) begin
            kw_pos = NmStop;
          end else if (kw_pos == NmSkip && is_blank(c)) begin
          end else begin
            kw_pos = NmCopy;
            if (name_limit != 0 && name_count + 1 < name_limit) begin
              name_count++;
              r.kind = KIND_NAME_CHAR;
              r.name_char = c;
              pending_results.push_back(r);
            end
          end
        end
        PH_ID: begin
          if (c == ChHash) begin
            if (id_digits == 0 || id_digits > 8) begin
              cur_phase = PH_ERROR;
            end else begin
              cur_phase = PH_DATA;
              nibbles = 0;
              data_word = '0;
            end
          end else if (c == ChNul) begin
            cur_phase = PH_ERROR;
          end else begin
            h = hex_val(c);
            if (h >= 0) begin
              frame_id = {frame_id[27:0], 4'(h)};
              if (id_digits < 9) id_digits++;
            end else begin
              frame_id = '0;
              id_digits = 0;
            end
          end
        end
        PH_DATA: begin
          h = hex_val(c);
          if (h >= 0) begin
            if (nibbles >= 2 * MaxBytes) begin
              cur_phase = PH_ERROR;
            end else begin
              // high nibble of each byte comes first
              sh = (nibbles / 2) * 8 + ((nibbles % 2 == 1) ? 0 : 4);
              data_word |= 64'(h) << sh;
              nibbles++;
            end
          end else if (nibbles % 2 == 1) begin
            cur_phase = PH_ERROR;
          end else begin
            cur_phase = PH_REST;
            kw_pos = KwIdle;
            tail_char(c);
          end
        end
        PH_REST: tail_char(c);
        default: begin
        end
      endcase
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("kind: expected no result beat, actual %0d", got.kind);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("name_char", want.name_char, got.name_char);
      check_field("can_id", want.can_id, got.can_id);
      check_field("byte_count", want.byte_count, got.byte_count);
      check_field("payload", want.payload, got.payload);
      check_field("repeat_count", want.repeat_count, got.repeat_count);
      check_field("frame_delay", want.frame_delay, got.frame_delay);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;

  cftlp_char_if   line_in();
  cftlp_result_if result_out();

  can_frame_text_line_parser_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .line_in    (line_in),
    .result_out (result_out),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  frame_line_checker sb = new;
  logic [7:0] line_q[$];
  int         items_sent = 0;
  int         burst_left = 0;

  always #6 clk = ~clk;

  // result beats
  always @(posedge clk) begin
    result_t got;
    if (!rst && result_out.valid && result_out.ready) begin
      got.kind = kind_t'(result_out.kind);
      got.name_char = result_out.name_char;
      got.can_id = result_out.can_id;
      got.byte_count = result_out.byte_count;
      got.payload = result_out.payload;
      got.repeat_count = result_out.repeat_count;
      got.frame_delay = result_out.frame_delay;
      sb.check_result(got);
    end
  end

  // receiver stalls in a randomly chosen pattern
  initial begin
    int stall_mode;
    int tick;
    stall_mode = 0;
    tick = 0;
    result_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: result_out.ready <= 1'b1;
        1: result_out.ready <= ($urandom_range(0, 1) == 1);
        2: result_out.ready <= (tick % 4 == 0);
        default: result_out.ready <= (tick % 32 >= 8);
      endcase
      tick++;
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input logic [7:0] c, input logic line_end);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        line_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    line_in.valid <= 1'b1;
    line_in.ch <= c;
    line_in.line_end <= line_end;
    do @(posedge clk); while (line_in.ready !== 1'b1);
    sb.take_char(c, line_end);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_beat(line_q[i], 1'b0);
    send_beat(8'($urandom), 1'b1);
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    line_in.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'(48 + v);
    return 8'(($urandom_range(0, 1) ? 97 : 65) + v - 10);
  endfunction

  function automatic void put_blanks(int most);
    repeat ($urandom_range(0, most)) line_q.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
  endfunction

  // letters in random case
  function automatic void put_word(string w);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      line_q.push_back(c);
    end
  endfunction

  function automatic void put_junk(int most, bit any_byte);
    repeat ($urandom_range(1, most))
      line_q.push_back(any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126)));
  endfunction

  function automatic void put_number();
    int unsigned v;
    string s;
    case ($urandom_range(0, 7))
      0: return;
      1: v = 0;
      2: v = 65535;
      3: v = 65536;
      4: v = $urandom;
      5: v = $urandom_range(0, 99);
      default: v = $urandom_range(0, 70000);
    endcase
    if ($urandom_range(0, 5) == 0) line_q.push_back("0");
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void put_frame();
    string partial[5] = '{"rep", "repeat", "delay", "dela=", "rrepeat="};
    logic [31:0] id;
    int n;
    int m;
    int k;
    int fill;
    put_blanks(2);
    if ($urandom_range(0, 9) == 0) put_word("can0 ");
    k = $urandom_range(0, 19);
    n = (k == 0) ? 0 : ((k == 1) ? $urandom_range(9, 10) : $urandom_range(1, 8));
    case ($urandom_range(0, 5))
      0, 1: begin
        id = sb.blocked_id;
        if (n >= 1 && n <= 8) n = 8;
      end
      2: id = '0;
      3: id = '1;
      default: id = $urandom;
    endcase
    for (int i = n - 1; i >= 0; i--)
      line_q.push_back(hex_char(i < 8 ? int'((id >> (4 * i)) & 32'hF) : $urandom_range(0, 15)));
    line_q.push_back(ChHash);
    k = $urandom_range(0, 9);
    m = (k == 0) ? $urandom_range(0, 7) * 2 + 1
                 : ((k == 1) ? $urandom_range(17, 18) : $urandom_range(0, 8) * 2);
    fill = $urandom_range(0, 7);
    for (int i = 0; i < m; i++)
      line_q.push_back(hex_char(fill == 0 ? 0 : (fill == 1 ? 15 : $urandom_range(0, 15))));
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) != 0) begin
        line_q.push_back(ChSpace);
        put_blanks(1);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          put_word("repeat=");
          put_number();
        end
        3, 4, 5: begin
          put_word("delay=");
          put_number();
        end
        6: begin
          put_word(partial[$urandom_range(0, 4)]);
          put_number();
        end
        7: put_junk(5, 1'b0);
        8: begin
          line_q.push_back(ChNul);
          put_junk(4, 1'b1);
        end
        default: begin
          put_word("repeat=");
          put_number();
          put_word("delay=");
          put_number();
        end
      endcase
    end
  endfunction

  function automatic void put_comment();
    int k;
    put_blanks(2);
    line_q.push_back(ChHash);
    put_blanks(2);
    k = $urandom_range(0, 7);
    if (k < 6) put_word("name:");
    else if (k == 6) put_word("nam");
    else put_word("title:");
    put_blanks(2);
    repeat (($urandom_range(0, 7) == 0) ? $urandom_range(28, 45) : $urandom_range(0, 12)) begin
      k = $urandom_range(0, 9);
      if (k == 0) line_q.push_back(ChSpace);
      else if (k == 1) line_q.push_back(8'($urandom_range(128, 255)));
      else line_q.push_back(8'($urandom_range(33, 126)));
    end
    case ($urandom_range(0, 5))
      0: begin
        line_q.push_back(ChCr);
        put_junk(6, 1'b0);
      end
      1: begin
        line_q.push_back(ChLf);
        put_junk(6, 1'b1);
      end
      2: begin
        line_q.push_back(ChNul);
        put_junk(6, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void build_line();
    int k;
    line_q.delete();
    k = $urandom_range(0, 19);
    if (k <= 10) begin
      put_frame();
    end else if (k <= 14) begin
      put_comment();
    end else if (k == 15) begin
      put_blanks(4);
      case ($urandom_range(0, 3))
        0: line_q.push_back(ChCr);
        1: line_q.push_back(ChLf);
        2: line_q.push_back(ChNul);
        default: begin
        end
      endcase
      if ($urandom_range(0, 1) == 1) put_junk(6, 1'b1);
    end else begin
      repeat ($urandom_range(0, 12))
        line_q.push_back(($urandom_range(0, 7) == 0) ? ChHash : 8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic run_lines(input int beats);
    int target;
    target = items_sent + beats;
    while (items_sent < target) begin
      build_line();
      send_line();
    end
  endtask

  initial begin
    line_in.valid = 1'b0;
    line_in.ch = '0;
    line_in.line_end = 1'b0;
    wr_en = 1'b0;
    wr_index = RegBlockedId;
    wr_data = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send_text("");
    send_text(" \r");
    send_text("#x");
    send_text("#nAme: ab\n");
    send_text("7#");
    send_text("g");
    line_q.delete();
    line_q.push_back(8'hff);
    line_q.push_back(ChNul);
    line_q.push_back("1");
    send_line();
    run_lines(PhaseBeats);

    settle();
    write_reg(RegBlockedId, 32'h0000_0000);
    write_reg(RegNameLimit, {24'($urandom), 8'd0});
    write_reg(RegSpareA, $urandom);
    write_reg(RegSpareB, $urandom);
    run_lines(PhaseBeats);

    settle();
    write_reg(RegBlockedId, 32'hFFFF_FFFF);
    write_reg(RegNameLimit, 32'hFFFF_FFFF);
    run_lines(PhaseBeats);

    settle();
    write_reg(RegBlockedId, $urandom);
    write_reg(RegNameLimit, {24'($urandom), 8'd1});
    run_lines(PhaseBeats);

    settle();
    write_reg(RegBlockedId, $urandom);
    write_reg(RegNameLimit, {24'd0, 8'($urandom_range(2, 12))});
    run_lines(PhaseBeats);

    settle();
    write_reg(RegBlockedId, BlockedIdReset);
    write_reg(RegNameLimit, {24'($urandom), NameLimitReset});
    run_lines(PhaseBeats);

    settle();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/cftlp_pkg.sv
rtl/core/cftlp_if.sv
rtl/core/cftlp_step.sv
rtl/core/can_frame_text_line_parser_unit.sv
verif/testbench.sv
